@@ hw/rtl/cansm_pkg.sv @@
// ----------------------------------------------------------------------------
// cansm_pkg
// Shared types and codes for the CAN network mode manager.
// ----------------------------------------------------------------------------
package cansm_pkg;

   localparam int CHANNEL_COUNT_DEFAULT = 1;

   localparam logic [7:0]  RETRY_LIMIT_RESET    = 8'd5;
   localparam logic [31:0] SHORT_INTERVAL_RESET = 32'd100;
   localparam logic [31:0] LONG_INTERVAL_RESET  = 32'd1000;
   localparam logic [31:0] WAKE_CHECK_RESET     = 32'd1000;
   localparam logic [7:0]  RETRY_MAX            = 8'd255;

   // register indexes
   localparam logic [1:0] REG_RETRY_LIMIT    = 2'd0;
   localparam logic [1:0] REG_SHORT_INTERVAL = 2'd1;
   localparam logic [1:0] REG_LONG_INTERVAL  = 2'd2;
   localparam logic [1:0] REG_WAKE_CHECK     = 2'd3;

   // event kinds
   localparam logic [2:0] KIND_REQUEST  = 3'd0;
   localparam logic [2:0] KIND_BUSOFF   = 3'd1;
   localparam logic [2:0] KIND_WAKEUP   = 3'd2;
   localparam logic [2:0] KIND_FRAME_RX = 3'd3;
   localparam logic [2:0] KIND_PERIODIC = 3'd4;

   // requested modes
   localparam logic [1:0] WANT_NOCOM   = 2'd0;
   localparam logic [1:0] WANT_SILENT  = 2'd1;
   localparam logic [1:0] WANT_FULL    = 2'd2;
   localparam logic [1:0] WANT_INVALID = 2'd3;

   // controller commands
   localparam logic [2:0] CMD_NONE   = 3'd0;
   localparam logic [2:0] CMD_START  = 3'd1;
   localparam logic [2:0] CMD_STOP   = 3'd2;
   localparam logic [2:0] CMD_SLEEP  = 3'd3;
   localparam logic [2:0] CMD_WAKEUP = 3'd4;

   // mode indications
   localparam logic [1:0] IND_NONE   = 2'd0;
   localparam logic [1:0] IND_NOCOM  = 2'd1;
   localparam logic [1:0] IND_SILENT = 2'd2;
   localparam logic [1:0] IND_FULL   = 2'd3;

   // reported current mode
   localparam logic [1:0] MODE_NOCOM  = 2'd0;
   localparam logic [1:0] MODE_SILENT = 2'd1;
   localparam logic [1:0] MODE_FULL   = 2'd2;

   typedef enum logic [2:0] {
      ST_NOCOM   = 3'd0,
      ST_SILENT  = 3'd1,
      ST_FULL    = 3'd2,
      ST_BUSOFF  = 3'd3,
      ST_WAKEVAL = 3'd4
   } state_type;

   typedef struct packed {
      logic [7:0]  short_retry_limit;
      logic [31:0] short_interval_ms;
      logic [31:0] long_interval_ms;
      logic [31:0] wake_check_ms;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] now_ms;
      logic [7:0]  network;
      logic [1:0]  wanted_mode;
   } item_type;

   typedef struct packed {
      logic       accepted;
      logic [2:0] ctrl_command;
      logic [1:0] mode_indication;
      logic [7:0] indication_network;
      logic       report_failed;
      logic       report_passed;
      logic [1:0] current_mode;
   } result_type;

endpackage

@@ hw/rtl/cansm_csr.sv @@
// ----------------------------------------------------------------------------
// cansm_csr
// APB-style configuration registers for the mode manager.
// ----------------------------------------------------------------------------
module cansm_csr
   import cansm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign wr_en     = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_RETRY_LIMIT:    cfg_in.short_retry_limit = pwdata[7:0];
            REG_SHORT_INTERVAL: cfg_in.short_interval_ms = pwdata;
            REG_LONG_INTERVAL:  cfg_in.long_interval_ms  = pwdata;
            REG_WAKE_CHECK:     cfg_in.wake_check_ms     = pwdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_RETRY_LIMIT:    prdata = {24'd0, cfg_ff.short_retry_limit};
         REG_SHORT_INTERVAL: prdata = cfg_ff.short_interval_ms;
         REG_LONG_INTERVAL:  prdata = cfg_ff.long_interval_ms;
         REG_WAKE_CHECK:     prdata = cfg_ff.wake_check_ms;
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_retry_limit <= RETRY_LIMIT_RESET;
         cfg_ff.short_interval_ms <= SHORT_INTERVAL_RESET;
         cfg_ff.long_interval_ms  <= LONG_INTERVAL_RESET;
         cfg_ff.wake_check_ms     <= WAKE_CHECK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/cansm_core.sv @@
// ----------------------------------------------------------------------------
// cansm_core
// Mode state machine with bus-off recovery and wakeup validation.
// ----------------------------------------------------------------------------
module cansm_core
   import cansm_pkg::*;
#(
   parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step_en,
   input  item_type   item,
   output result_type result
);

   state_type   state_ff, state_in;
   logic [31:0] busoff_start_ff, busoff_start_in;
   logic [31:0] wake_start_ff, wake_start_in;
   logic [7:0]  retry_ff, retry_in;

   logic        bad_net;
   logic [31:0] busoff_elapsed;
   logic [31:0] wake_elapsed;
   logic [31:0] interval;
   logic [7:0]  retry_inc;

   assign bad_net        = {1'b0, item.network} >= 9'(CHANNEL_COUNT);
   assign busoff_elapsed = item.now_ms - busoff_start_ff;
   assign wake_elapsed   = item.now_ms - wake_start_ff;
   assign interval       = (retry_ff >= cfg.short_retry_limit) ? cfg.long_interval_ms
                                                               : cfg.short_interval_ms;
   assign retry_inc      = retry_ff + 8'd1;

   always_comb begin
      state_in        = state_ff;
      busoff_start_in = busoff_start_ff;
      wake_start_in   = wake_start_ff;
      retry_in        = retry_ff;
      result          = '0;
      result.accepted = 1'b1;

      case (item.kind)
         KIND_REQUEST: begin
            if (bad_net || state_ff == ST_BUSOFF || item.wanted_mode == WANT_INVALID) begin
               result.accepted = 1'b0;
            end else if (item.wanted_mode == WANT_FULL) begin
               result.ctrl_command       = CMD_START;
               result.report_passed      = 1'b1;
               result.mode_indication    = IND_FULL;
               result.indication_network = item.network;
               state_in                  = ST_FULL;
               retry_in                  = 8'd0;
            end else if (item.wanted_mode == WANT_SILENT) begin
               if (state_ff == ST_FULL) result.ctrl_command = CMD_STOP;
               result.mode_indication    = IND_SILENT;
               result.indication_network = item.network;
               state_in                  = ST_SILENT;
            end else begin
               if (state_ff == ST_FULL) result.ctrl_command = CMD_SLEEP;
               result.mode_indication    = IND_NOCOM;
               result.indication_network = item.network;
               state_in                  = ST_NOCOM;
            end
         end
         KIND_BUSOFF: begin
            if (state_ff == ST_FULL) begin
               result.ctrl_command    = CMD_STOP;
               result.mode_indication = IND_SILENT;
               state_in               = ST_BUSOFF;
               busoff_start_in        = item.now_ms;
            end
         end
         KIND_WAKEUP: begin
            if (state_ff == ST_NOCOM) begin
               result.ctrl_command = CMD_WAKEUP;
               state_in            = ST_WAKEVAL;
               wake_start_in       = item.now_ms;
            end
         end
         KIND_FRAME_RX: begin
            if (state_ff == ST_WAKEVAL) begin
               result.ctrl_command    = CMD_START;
               result.report_passed   = 1'b1;
               result.mode_indication = IND_FULL;
               state_in               = ST_FULL;
               retry_in               = 8'd0;
            end
         end
         KIND_PERIODIC: begin
            if (state_ff == ST_WAKEVAL) begin
               if (wake_elapsed >= cfg.wake_check_ms) begin
                  result.ctrl_command = CMD_SLEEP;
                  state_in            = ST_NOCOM;
               end
            end else if (state_ff == ST_BUSOFF) begin
               if (busoff_elapsed >= interval) begin
                  // counter saturates; FAILED only on a real step to limit+1
                  if (retry_ff != RETRY_MAX) begin
                     retry_in = retry_inc;
                     result.report_failed =
                        ({1'b0, retry_inc} == ({1'b0, cfg.short_retry_limit} + 9'd1));
                  end
                  result.ctrl_command    = CMD_START;
                  result.report_passed   = 1'b1;
                  result.mode_indication = IND_FULL;
                  state_in               = ST_FULL;
               end
            end
         end
         default: result.accepted = 1'b0;
      endcase

      // mode after the step
      if (state_in == ST_FULL)        result.current_mode = MODE_FULL;
      else if (state_in == ST_SILENT) result.current_mode = MODE_SILENT;
      else                            result.current_mode = MODE_NOCOM;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_NOCOM;
         busoff_start_ff <= 32'd0;
         wake_start_ff   <= 32'd0;
         retry_ff        <= 8'd0;
      end else if (step_en) begin
         state_ff        <= state_in;
         busoff_start_ff <= busoff_start_in;
         wake_start_ff   <= wake_start_in;
         retry_ff        <= retry_in;
      end
   end

`ifndef ASSERT_OFF
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(state_ff) && $stable(retry_ff))
      else $error("state changed without a step");

   a_busoff_entry: assert property (@(posedge clock) disable iff (reset)
      step_en && state_in == ST_BUSOFF && state_ff != ST_BUSOFF |-> state_ff == ST_FULL)
      else $error("bus-off entered from a state other than full");

   a_failed_start: assert property (@(posedge clock) disable iff (reset)
      step_en && result.report_failed |->
         result.report_passed && result.ctrl_command == CMD_START && state_ff == ST_BUSOFF)
      else $error("FAILED reported outside a bus-off recovery");

   a_busoff_reject: assert property (@(posedge clock) disable iff (reset)
      step_en && state_ff == ST_BUSOFF && item.kind == KIND_REQUEST |->
         !result.accepted && state_in == ST_BUSOFF)
      else $error("request taken during bus-off");
`endif

endmodule

@@ hw/rtl/can_network_mode_busoff_recovery_core.sv @@
// ----------------------------------------------------------------------------
// can_network_mode_busoff_recovery_core
// CAN network mode manager: no-com, silent, full, bus-off and wakeup
// validation, with endless two-level bus-off recovery.
// ----------------------------------------------------------------------------
//
// channel  direction  handshake                 payload
// req_     in         req_tvalid / req_tready    tdata: now_ms, network, wanted_mode
//                                                tuser: kind
// rsp_     out        rsp_tvalid / rsp_tready    tdata: result fields
// csr_     in         APB write, pready high     4 registers at 4*i
//
// One transaction per cycle sustained while rsp_tready stays high; a result
// passes through the input register, then the result register.
// The mode state updates when an item moves from the input register into the
// result register, so the per-item path is one pass through the state logic.
// Reset (synchronous, high) empties both registers and returns the manager to
// no-com with the register defaults.
// A stalled result holds; the input register still takes one more transaction
// and then req_tready follows rsp_tready.
// ----------------------------------------------------------------------------
module can_network_mode_busoff_recovery_core
   import cansm_pkg::*;
#(
   parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] now_ms, [39:32] network, [41:40] wanted_mode, [47:42] zero
   input  logic [47:0] req_tdata,
   // [2:0] kind
   input  logic [2:0]  req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] accepted, [3:1] ctrl_command, [5:4] mode_indication,
   // [13:6] indication_network, [14] report_failed, [15] report_passed,
   // [17:16] current_mode, [23:18] zero
   output logic [23:0] rsp_tdata,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type result;
   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       req_fire;

   cansm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // item leaves the input register when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      item_in.kind        = req_tuser;
      item_in.now_ms      = req_tdata[31:0];
      item_in.network     = req_tdata[39:32];
      item_in.wanted_mode = req_tdata[41:40];
      in_valid_in         = req_fire || (in_valid_ff && !advance);
      out_in              = result;
      out_valid_in        = advance || (out_valid_ff && !rsp_tready);
   end

   cansm_core #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .item    (item_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) item_ff <= item_in;
      if (advance)  out_ff  <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0,
                        out_ff.current_mode,
                        out_ff.report_passed,
                        out_ff.report_failed,
                        out_ff.indication_network,
                        out_ff.mode_indication,
                        out_ff.ctrl_command,
                        out_ff.accepted};

endmodule

@@ bench/cansm_mode_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cansm_mode_checker
// Watches the event, result and register ports of the CAN mode manager,
// predicts one result per event transaction and compares it field by field.
// ----------------------------------------------------------------------------
module cansm_mode_checker
   import cansm_pkg::*;
#(
   parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          error_count,
   output int          outstanding
);

   cfg_type    cfg;
   state_type  mgr_state;
   logic [31:0] busoff_t0;
   logic [31:0] wake_t0;
   logic [7:0]  retry_cnt;

   result_type expected_results[$];
   result_type want_result;
   result_type seen_result;
   item_type   seen_item;
   int         result_index;

   initial error_count = 0;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string field, input int unsigned got,
                              input int unsigned want);
      if (got != want) begin
         report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                   result_index, field, got, want));
      end
   endtask

   // Advances the manager state by one event and returns its result.
   function automatic result_type next_mode_result(input item_type ev);
      result_type  r;
      logic [31:0] elapsed;
      logic [31:0] wait_ms;
      r = '0;
      r.accepted = 1'b1;
      case (ev.kind)
         KIND_REQUEST: begin
            if (ev.network >= CHANNEL_COUNT || mgr_state == ST_BUSOFF ||
                ev.wanted_mode == WANT_INVALID) begin
               r.accepted = 1'b0;
            end else if (ev.wanted_mode == WANT_FULL) begin
               r.ctrl_command       = CMD_START;
               mgr_state            = ST_FULL;
               retry_cnt            = '0;
               r.report_passed      = 1'b1;
               r.mode_indication    = IND_FULL;
               r.indication_network = ev.network;
            end else if (ev.wanted_mode == WANT_SILENT) begin
               if (mgr_state == ST_FULL) r.ctrl_command = CMD_STOP;
               mgr_state            = ST_SILENT;
               r.mode_indication    = IND_SILENT;
               r.indication_network = ev.network;
            end else begin
               if (mgr_state == ST_FULL) r.ctrl_command = CMD_SLEEP;
               mgr_state            = ST_NOCOM;
               r.mode_indication    = IND_NOCOM;
               r.indication_network = ev.network;
            end
         end
         KIND_BUSOFF: begin
            if (mgr_state == ST_FULL) begin
               r.ctrl_command    = CMD_STOP;
               mgr_state         = ST_BUSOFF;
               busoff_t0         = ev.now_ms;
               r.mode_indication = IND_SILENT;
            end
         end
         KIND_WAKEUP: begin
            if (mgr_state == ST_NOCOM) begin
               r.ctrl_command = CMD_WAKEUP;
               mgr_state      = ST_WAKEVAL;
               wake_t0        = ev.now_ms;
            end
         end
         KIND_FRAME_RX: begin
            if (mgr_state == ST_WAKEVAL) begin
               r.ctrl_command    = CMD_START;
               mgr_state         = ST_FULL;
               retry_cnt         = '0;
               r.report_passed   = 1'b1;
               r.mode_indication = IND_FULL;
            end
         end
         KIND_PERIODIC: begin
            if (mgr_state == ST_WAKEVAL) begin
               elapsed = ev.now_ms - wake_t0;
               if (elapsed >= cfg.wake_check_ms) begin
                  r.ctrl_command = CMD_SLEEP;
                  mgr_state      = ST_NOCOM;
               end
            end else if (mgr_state == ST_BUSOFF) begin
               wait_ms = (retry_cnt >= cfg.short_retry_limit) ?
                         cfg.long_interval_ms : cfg.short_interval_ms;
               elapsed = ev.now_ms - busoff_t0;
               if (elapsed >= wait_ms) begin
                  // counter saturates; FAILED only on a real step to limit+1
                  if (retry_cnt != RETRY_MAX) begin
                     retry_cnt = retry_cnt + 8'd1;
                     if ({1'b0, retry_cnt} == {1'b0, cfg.short_retry_limit} + 9'd1)
                        r.report_failed = 1'b1;
                  end
                  r.ctrl_command    = CMD_START;
                  mgr_state         = ST_FULL;
                  r.report_passed   = 1'b1;
                  r.mode_indication = IND_FULL;
               end
            end
         end
         default: r.accepted = 1'b0;
      endcase
      case (mgr_state)
         ST_FULL:   r.current_mode = MODE_FULL;
         ST_SILENT: r.current_mode = MODE_SILENT;
         default:   r.current_mode = MODE_NOCOM;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.short_retry_limit = RETRY_LIMIT_RESET;
         cfg.short_interval_ms = SHORT_INTERVAL_RESET;
         cfg.long_interval_ms  = LONG_INTERVAL_RESET;
         cfg.wake_check_ms     = WAKE_CHECK_RESET;
         mgr_state             = ST_NOCOM;
         busoff_t0             = '0;
         wake_t0               = '0;
         retry_cnt             = '0;
         result_index          = 0;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_RETRY_LIMIT:    cfg.short_retry_limit = csr_pwdata[7:0];
               REG_SHORT_INTERVAL: cfg.short_interval_ms = csr_pwdata;
               REG_LONG_INTERVAL:  cfg.long_interval_ms  = csr_pwdata;
               REG_WAKE_CHECK:     cfg.wake_check_ms     = csr_pwdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            // tdata carries the first field in the lowest bit
            seen_result.accepted           = rsp_tdata[0];
            seen_result.ctrl_command       = rsp_tdata[3:1];
            seen_result.mode_indication    = rsp_tdata[5:4];
            seen_result.indication_network = rsp_tdata[13:6];
            seen_result.report_failed      = rsp_tdata[14];
            seen_result.report_passed      = rsp_tdata[15];
            seen_result.current_mode       = rsp_tdata[17:16];
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result %0d with none expected", result_index));
            end else begin
               want_result = expected_results.pop_front();
               check_field("accepted", seen_result.accepted, want_result.accepted);
               check_field("ctrl_command", seen_result.ctrl_command,
                           want_result.ctrl_command);
               check_field("mode_indication", seen_result.mode_indication,
                           want_result.mode_indication);
               check_field("indication_network", seen_result.indication_network,
                           want_result.indication_network);
               check_field("report_failed", seen_result.report_failed,
                           want_result.report_failed);
               check_field("report_passed", seen_result.report_passed,
                           want_result.report_passed);
               check_field("current_mode", seen_result.current_mode,
                           want_result.current_mode);
            end
            result_index++;
         end
         if (req_tvalid && req_tready) begin
            seen_item.kind        = req_tuser;
            seen_item.now_ms      = req_tdata[31:0];
            seen_item.network     = req_tdata[39:32];
            seen_item.wanted_mode = req_tdata[41:40];
            expected_results.push_back(next_mode_result(seen_item));
         end
      end
      outstanding <= expected_results.size();
   end

endmodule

@@ bench/can_network_mode_busoff_recovery_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// can_network_mode_busoff_recovery_core_tb
// Drives mode requests and bus-off, wakeup, frame and periodic events into the
// CAN mode manager under several register settings; a checker beside the
// block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module can_network_mode_busoff_recovery_core_tb;
   import cansm_pkg::*;

   // highest code on the 3-bit kind field; codes above KIND_PERIODIC are unknown
   localparam logic [2:0] KIND_LAST_CODE = 3'd7;
   // cycles without any transaction before the run is declared hung
   localparam int STALL_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // [31:0] now_ms, [39:32] network, [41:40] wanted_mode, [47:42] zero
   logic [47:0] req_tdata;
   // [2:0] kind
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [0] accepted, [3:1] ctrl_command, [5:4] mode_indication,
   // [13:6] indication_network, [14] report_failed, [15] report_passed,
   // [17:16] current_mode, [23:18] zero
   logic [23:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          error_count;
   int          outstanding;
   int          idle_cycles;
   // when set, neither side inserts gaps or stalls
   logic        steady;
   // running millisecond clock carried in the event transactions
   logic [31:0] ms_now;

   can_network_mode_busoff_recovery_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   cansm_mode_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: back-pressure about a third of the cycles unless steady.
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 32);
   end

   // Watchdog: ends the run when no transaction of any kind moves for too long.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // One event transaction, preceded by random gaps on the request side.
   task automatic push_event(input logic [2:0] kind, input logic [31:0] now,
                             input logic [7:0] net, input logic [1:0] want);
      while (!steady && $urandom_range(0, 99) < 32) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, want, net, now};
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready.
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_regs(input logic [7:0] limit, input logic [31:0] short_ms,
                               input logic [31:0] long_ms, input logic [31:0] wake_ms);
      csr_write(REG_RETRY_LIMIT, {24'b0, limit});
      csr_write(REG_SHORT_INTERVAL, short_ms);
      csr_write(REG_LONG_INTERVAL, long_ms);
      csr_write(REG_WAKE_CHECK, wake_ms);
   endtask

   // Drops valid and waits until every predicted result has come back, plus
   // the block's two-stage pipeline.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Mostly well-formed traffic: requests to network 0, bus-off events and
   // periodic checks dominate, so recovery and wakeup timing are reached often.
   // Time advances by random steps and now and then jumps anywhere.
   task automatic random_events(input int count, input int step_max);
      int          pick;
      logic [2:0]  kind;
      logic [7:0]  net;
      logic [1:0]  want;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 18)      kind = KIND_REQUEST;
         else if (pick < 33) kind = KIND_BUSOFF;
         else if (pick < 43) kind = KIND_WAKEUP;
         else if (pick < 53) kind = KIND_FRAME_RX;
         else if (pick < 96) kind = KIND_PERIODIC;
         else                kind = 3'($urandom_range(KIND_PERIODIC + 1, KIND_LAST_CODE));
         ms_now = ms_now + $urandom_range(0, step_max);
         if ($urandom_range(0, 99) < 3) ms_now = $urandom;
         if (kind == KIND_REQUEST) begin
            net  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
            pick = $urandom_range(0, 9);
            if (pick < 2)      want = WANT_NOCOM;
            else if (pick < 4) want = WANT_SILENT;
            else if (pick < 9) want = WANT_FULL;
            else               want = WANT_INVALID;
         end else begin
            net  = 8'($urandom);
            want = 2'($urandom);
         end
         push_event(kind, ms_now, net, want);
      end
   endtask

   initial begin
      reset       = 1'b1;
      steady      = 1'b0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      ms_now      = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed, reset register values (limit 5, 100 / 1000 / 1000 ms) ----
      push_event(KIND_REQUEST, 32'd0, 8'd0, WANT_FULL);         // start, full
      push_event(KIND_REQUEST, 32'd0, 8'hFF, WANT_FULL);        // bad network
      push_event(KIND_REQUEST, 32'd0, 8'd0, WANT_INVALID);      // invalid mode
      push_event(KIND_BUSOFF, 32'd10, 8'd0, WANT_NOCOM);        // enter bus-off
      push_event(KIND_REQUEST, 32'd20, 8'd0, WANT_FULL);        // rejected in bus-off
      push_event(KIND_PERIODIC, 32'd50, 8'd0, WANT_NOCOM);      // too early
      push_event(KIND_PERIODIC, 32'd110, 8'd0, WANT_NOCOM);     // exactly due
      push_event(KIND_REQUEST, 32'd120, 8'd0, WANT_SILENT);     // full -> silent, stop
      push_event(KIND_BUSOFF, 32'd130, 8'd0, WANT_NOCOM);       // ignored outside full
      push_event(KIND_REQUEST, 32'd140, 8'd0, WANT_NOCOM);      // silent -> no-com, no cmd
      push_event(KIND_FRAME_RX, 32'd150, 8'd0, WANT_NOCOM);     // ignored
      push_event(KIND_PERIODIC, 32'd160, 8'd0, WANT_NOCOM);     // ignored
      push_event(KIND_WAKEUP, 32'hFFFF_FF00, 8'd0, WANT_NOCOM); // wakeup, validating
      push_event(KIND_WAKEUP, 32'hFFFF_FF10, 8'd0, WANT_NOCOM); // ignored
      push_event(KIND_PERIODIC, 32'h0000_0100, 8'd0, WANT_NOCOM); // wrapped, not due
      push_event(KIND_PERIODIC, 32'h0000_02E8, 8'd0, WANT_NOCOM); // due: back to sleep
      push_event(KIND_WAKEUP, 32'd5, 8'd0, WANT_NOCOM);
      push_event(KIND_REQUEST, 32'd6, 8'd0, WANT_SILENT);       // validating -> silent
      push_event(KIND_REQUEST, 32'd7, 8'd0, WANT_FULL);
      push_event(KIND_REQUEST, 32'd8, 8'd0, WANT_NOCOM);        // full -> no-com, sleep
      for (int k = KIND_PERIODIC + 1; k <= KIND_LAST_CODE; k++)
         push_event(3'(k), 32'hFFFF_FFFF, 8'hFF, WANT_INVALID); // unknown kinds
      push_event(KIND_WAKEUP, 32'd9, 8'd0, WANT_NOCOM);
      push_event(KIND_FRAME_RX, 32'd10, 8'd0, WANT_NOCOM);      // confirmed: full
      wait_drained();

      // ---- short limit, small intervals: FAILED crossing and long level ----
      program_regs(8'd2, 32'd5, 32'd40, 32'd30);
      random_events(350, 60);
      wait_drained();

      // ---- zero waits, recovery loop up to counter saturation, no gaps ----
      steady = 1'b1;
      program_regs(8'd253, 32'd0, 32'd0, 32'd0);
      push_event(KIND_REQUEST, $urandom, 8'd0, WANT_FULL);
      for (int n = 0; n < 260; n++) begin
         push_event(KIND_BUSOFF, $urandom, 8'($urandom), 2'($urandom));
         push_event(KIND_PERIODIC, $urandom, 8'($urandom), 2'($urandom));
      end
      wait_drained();
      steady = 1'b0;

      // ---- limit at maximum, extreme intervals ----
      program_regs(8'hFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      random_events(250, 200);
      wait_drained();

      // ---- limit zero: long level from the first retry, time wraps ----
      ms_now = 32'hFFFF_F000;
      program_regs(8'd0, 32'hFFFF_FFFF, 32'd50, 32'd200);
      random_events(300, 80);
      wait_drained();

      // ---- random moderate settings ----
      program_regs(8'($urandom_range(0, 4)), $urandom_range(0, 150),
                   $urandom_range(100, 600), $urandom_range(0, 400));
      random_events(250, 120);
      wait_drained();

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
